// ----- src/qv4alu_pkg.sv -----
`timescale 1ns / 1ps

package qv4alu_pkg;

    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_NEGATE  = 4'd2,
        CMD_SCALE   = 4'd3,
        CMD_COMPMUL = 4'd4,
        CMD_DOT     = 4'd5,
        CMD_CROSS   = 4'd6,
        CMD_QUATMUL = 4'd7,
        CMD_MAGSQ   = 4'd8,
        CMD_EQUAL   = 4'd9
    } cmd_t;

endpackage

// ----- src/quaternion_vector4_alu_core.sv -----
// An accepted request passes through four register stages up to the output register.
// Throughput: one request per cycle while the output is not stalled; operand select,
// the sixteen 32x32 multipliers with their fraction shifts, the sum network and
// saturation each take one register stage.
// A stalled output holds every stage in place, so the input stalls in the same cycle.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module quaternion_vector4_alu_core
    import qv4alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [3:0]               cmd,
    input  logic signed [DATA_W-1:0] a_x,
    input  logic signed [DATA_W-1:0] a_y,
    input  logic signed [DATA_W-1:0] a_z,
    input  logic signed [DATA_W-1:0] a_w,
    input  logic signed [DATA_W-1:0] b_x,
    input  logic signed [DATA_W-1:0] b_y,
    input  logic signed [DATA_W-1:0] b_z,
    input  logic signed [DATA_W-1:0] b_w,
    input  logic signed [DATA_W-1:0] scale,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] r_x,
    output logic signed [DATA_W-1:0] r_y,
    output logic signed [DATA_W-1:0] r_z,
    output logic signed [DATA_W-1:0] r_w,
    output logic                     equal_flag,
    output logic                     overflow
);

    localparam int FULL_W = 2 * DATA_W;
    localparam int PROD_W = FULL_W - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LIN_W  = DATA_W + 1;

    logic advance;

    logic signed [DATA_W-1:0] a_in [LANES];
    logic signed [DATA_W-1:0] b_in [LANES];

    // Stage 1: operands and the linear results.
    logic                     v1_reg;
    cmd_t                     cmd1_reg;
    cmd_t                     cmd1_next;
    logic signed [DATA_W-1:0] a1_reg [LANES];
    logic signed [DATA_W-1:0] m1_reg [LANES];
    logic signed [DATA_W-1:0] m1_next [LANES];
    logic signed [LIN_W-1:0]  lin1_reg [LANES];
    logic signed [LIN_W-1:0]  lin1_next [LANES];
    logic                     eq1_reg;
    logic                     eq1_next;

    // Stage 2: floored products.
    logic                     v2_reg;
    cmd_t                     cmd2_reg;
    logic signed [PROD_W-1:0] p2_reg [LANES][LANES];
    logic signed [PROD_W-1:0] p2_next [LANES][LANES];
    logic signed [LIN_W-1:0]  lin2_reg [LANES];
    logic                     eq2_reg;

    // Stage 3: exact sums.
    logic                     v3_reg;
    logic signed [SUM_W-1:0]  s3_reg [LANES];
    logic signed [SUM_W-1:0]  s3_next [LANES];
    logic                     eq3_reg;

    // Stage 4: saturated output.
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] r_reg [LANES];
    logic signed [DATA_W-1:0] r_next [LANES];
    logic                     eq_out_reg;
    logic                     ovf_reg;
    logic                     ovf_next;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign a_in[3] = a_w;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;
    assign b_in[3] = b_w;

    always_comb
    begin
        cmd1_next = cmd_t'(cmd);
        eq1_next  = (cmd1_next == CMD_EQUAL);
        for (int i = 0; i < LANES; i++)
        begin
            unique case (cmd1_next)
                CMD_SCALE: m1_next[i] = scale;
                CMD_MAGSQ: m1_next[i] = a_in[i];
                default:   m1_next[i] = b_in[i];
            endcase
            unique case (cmd1_next)
                CMD_ADD:    lin1_next[i] = LIN_W'(a_in[i]) + LIN_W'(b_in[i]);
                CMD_SUB:    lin1_next[i] = LIN_W'(a_in[i]) - LIN_W'(b_in[i]);
                CMD_NEGATE: lin1_next[i] = LIN_W'(0) - LIN_W'(a_in[i]);
                default:    lin1_next[i] = '0;
            endcase
            if (a_in[i] != b_in[i])
            begin
                eq1_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        logic signed [FULL_W-1:0] prod;
        logic signed [FULL_W-1:0] shifted;
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                prod          = FULL_W'(a1_reg[i]) * FULL_W'(m1_reg[j]);
                shifted       = prod >>> FRAC_BITS;
                p2_next[i][j] = shifted[PROD_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] e [LANES][LANES];
        for (int i = 0; i < LANES; i++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                e[i][j] = SUM_W'(p2_reg[i][j]);
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            s3_next[i] = '0;
        end
        unique case (cmd2_reg)
            CMD_ADD, CMD_SUB, CMD_NEGATE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    s3_next[i] = SUM_W'(lin2_reg[i]);
                end
            end
            CMD_SCALE, CMD_COMPMUL:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    s3_next[i] = e[i][i];
                end
            end
            CMD_DOT, CMD_MAGSQ:
            begin
                s3_next[0] = e[0][0] + e[1][1] + e[2][2] + e[3][3];
            end
            CMD_CROSS:
            begin
                s3_next[0] = e[1][2] - e[2][1];
                s3_next[1] = e[2][0] - e[0][2];
                s3_next[2] = e[0][1] - e[1][0];
            end
            CMD_QUATMUL:
            begin
                s3_next[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
                s3_next[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
                s3_next[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
                s3_next[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        logic [SUM_W-DATA_W:0] top;
        ovf_next = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            top = s3_reg[i][SUM_W-1:DATA_W-1];
            if ((&top) || !(|top))
            begin
                r_next[i] = s3_reg[i][DATA_W-1:0];
            end
            else
            begin
                ovf_next  = 1'b1;
                r_next[i] = s3_reg[i][SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                               : {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd1_reg   <= cmd1_next;
            eq1_reg    <= eq1_next;
            cmd2_reg   <= cmd1_reg;
            eq2_reg    <= eq1_reg;
            eq3_reg    <= eq2_reg;
            eq_out_reg <= eq3_reg;
            ovf_reg    <= ovf_next;
            for (int i = 0; i < LANES; i++)
            begin
                a1_reg[i]   <= a_in[i];
                m1_reg[i]   <= m1_next[i];
                lin1_reg[i] <= lin1_next[i];
                lin2_reg[i] <= lin1_reg[i];
                s3_reg[i]   <= s3_next[i];
                r_reg[i]    <= r_next[i];
                for (int j = 0; j < LANES; j++)
                begin
                    p2_reg[i][j] <= p2_next[i][j];
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign r_x        = r_reg[0];
    assign r_y        = r_reg[1];
    assign r_z        = r_reg[2];
    assign r_w        = r_reg[3];
    assign equal_flag = eq_out_reg;
    assign overflow   = ovf_reg;

`ifndef SYNTHESIS
    // The equality test produces no vector and can never saturate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && equal_flag) |-> (r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0
                                       && !overflow))
    else $error("equality result carries a nonzero vector or overflow");

    // A saturated result always shows one component pinned at a range limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
            (r_x == 32'sh7fffffff || r_x == -32'sh80000000 ||
             r_y == 32'sh7fffffff || r_y == -32'sh80000000 ||
             r_z == 32'sh7fffffff || r_z == -32'sh80000000 ||
             r_w == 32'sh7fffffff || r_w == -32'sh80000000))
    else $error("overflow raised without a saturated component");

    // A request that meets no stall on its way through the stages reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
    else $error("request lost in the pipeline");
`endif

endmodule

// ----- dv/tb_quaternion_vector4_alu_core.sv -----
`timescale 1ns / 1ps

module tb_quaternion_vector4_alu_core;
    import qv4alu_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [DATA_W-1:0] MAX_WORD = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MIN_WORD = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_WORD = 32'h0001_0000;
    localparam logic [DATA_W-1:0] NEG_LSB  = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] NEG_HALF = 32'hffff_8000;
    localparam logic [DATA_W-1:0] ZERO     = 32'h0000_0000;

    localparam logic [3:0] CMD_FIRST_UNUSED = 4'(CMD_EQUAL + 1);
    localparam logic [3:0] CMD_LAST_CODE    = '1;

    localparam longint SAT_MAX = 64'sh0000_0000_7fff_ffff;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    typedef struct packed {
        logic [3:0]                   cmd;
        logic [LANES-1:0][DATA_W-1:0] a;
        logic [LANES-1:0][DATA_W-1:0] b;
        logic [DATA_W-1:0]            factor;
    } alu_request_t;

    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] r;
        logic                         eq;
        logic                         ov;
    } alu_result_t;

    class alu_scoreboard;
        alu_result_t expected_q[$];
        int          failures;
        string       lane_name[LANES];

        function new();
            lane_name = '{"r_x", "r_y", "r_z", "r_w"};
            failures = 0;
        endfunction

        static function longint fixed_mul(longint x, longint y);
            return (x * y) >>> FRAC_BITS_DEF;
        endfunction

        static function alu_result_t vector_result(alu_request_t req);
            longint      a[LANES];
            longint      b[LANES];
            longint      r[LANES];
            longint      s;
            alu_result_t res;
            for (int i = 0; i < LANES; i++)
            begin
                a[i] = longint'($signed(req.a[i]));
                b[i] = longint'($signed(req.b[i]));
                r[i] = 0;
            end
            s = longint'($signed(req.factor));
            res = '0;
            case (req.cmd)
                CMD_ADD:
                    for (int i = 0; i < LANES; i++) r[i] = a[i] + b[i];
                CMD_SUB:
                    for (int i = 0; i < LANES; i++) r[i] = a[i] - b[i];
                CMD_NEGATE:
                    for (int i = 0; i < LANES; i++) r[i] = -a[i];
                CMD_SCALE:
                    for (int i = 0; i < LANES; i++) r[i] = fixed_mul(a[i], s);
                CMD_COMPMUL:
                    for (int i = 0; i < LANES; i++) r[i] = fixed_mul(a[i], b[i]);
                CMD_DOT:
                    for (int i = 0; i < LANES; i++) r[0] += fixed_mul(a[i], b[i]);
                CMD_CROSS:
                begin
                    r[0] = fixed_mul(a[1], b[2]) - fixed_mul(a[2], b[1]);
                    r[1] = fixed_mul(a[2], b[0]) - fixed_mul(a[0], b[2]);
                    r[2] = fixed_mul(a[0], b[1]) - fixed_mul(a[1], b[0]);
                end
                CMD_QUATMUL:
                begin
                    r[0] = fixed_mul(a[0], b[0]) - fixed_mul(a[1], b[1])
                         - fixed_mul(a[2], b[2]) - fixed_mul(a[3], b[3]);
                    r[1] = fixed_mul(a[0], b[1]) + fixed_mul(a[1], b[0])
                         + fixed_mul(a[2], b[3]) - fixed_mul(a[3], b[2]);
                    r[2] = fixed_mul(a[0], b[2]) - fixed_mul(a[1], b[3])
                         + fixed_mul(a[2], b[0]) + fixed_mul(a[3], b[1]);
                    r[3] = fixed_mul(a[0], b[3]) + fixed_mul(a[1], b[2])
                         - fixed_mul(a[2], b[1]) + fixed_mul(a[3], b[0]);
                end
                CMD_MAGSQ:
                    for (int i = 0; i < LANES; i++) r[0] += fixed_mul(a[i], a[i]);
                CMD_EQUAL:
                    res.eq = (req.a == req.b);
                default:
                    ;
            endcase
            for (int i = 0; i < LANES; i++)
            begin
                if (r[i] > SAT_MAX)
                begin
                    r[i] = SAT_MAX;
                    res.ov = 1'b1;
                end
                if (r[i] < SAT_MIN)
                begin
                    r[i] = SAT_MIN;
                    res.ov = 1'b1;
                end
                res.r[i] = DATA_W'(r[i]);
            end
            return res;
        endfunction

        function void note_request(alu_request_t req);
            expected_q.push_back(vector_result(req));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(alu_result_t got);
            alu_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("Result arrived with no request outstanding.");
                failures++;
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < LANES; i++)
            begin
                if (got.r[i] !== want.r[i])
                begin
                    $error("%s mismatch: expected %0d, got %0d", lane_name[i],
                           $signed(want.r[i]), $signed(got.r[i]));
                    failures++;
                end
            end
            if (got.eq !== want.eq)
            begin
                $error("equal_flag mismatch: expected %0b, got %0b", want.eq, got.eq);
                failures++;
            end
            if (got.ov !== want.ov)
            begin
                $error("overflow mismatch: expected %0b, got %0b", want.ov, got.ov);
                failures++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [3:0]               cmd;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] scale;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_z;
    logic signed [DATA_W-1:0] r_w;
    logic                     equal_flag;
    logic                     overflow;

    alu_scoreboard board;
    alu_result_t   seen;
    int            in_idle_pct = 12;
    int            out_idle_pct = 69;
    int            quiet_cycles = 0;

    quaternion_vector4_alu_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .a_w        (a_w),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .b_w        (b_w),
        .scale      (scale),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .r_x        (r_x),
        .r_y        (r_y),
        .r_z        (r_z),
        .r_w        (r_w),
        .equal_flag (equal_flag),
        .overflow   (overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.r  = {r_w, r_z, r_y, r_x};
            seen.eq = equal_flag;
            seen.ov = overflow;
            board.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(9))
            0:       w = MAX_WORD;
            1:       w = MIN_WORD;
            2:       w = ZERO;
            3, 4:    w = $urandom_range(1 << 18);
            5:       w = $urandom_range(1 << 24);
            default: w = $urandom;
        endcase
        if ($urandom_range(1))
            w = -w;
        return w;
    endfunction

    function automatic alu_request_t random_request();
        alu_request_t req;
        int           lane;
        int           bit_idx;
        for (int i = 0; i < LANES; i++)
        begin
            req.a[i] = random_word();
            req.b[i] = random_word();
        end
        req.factor = random_word();
        if ($urandom_range(99) < 4)
            req.cmd = 4'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
        else
            req.cmd = 4'($urandom_range(CMD_EQUAL, CMD_ADD));
        if (req.cmd == CMD_EQUAL && $urandom_range(9) < 7)
        begin
            req.b = req.a;
            if ($urandom_range(1))
            begin
                lane = $urandom_range(LANES - 1);
                bit_idx = $urandom_range(DATA_W - 1);
                req.b[lane][bit_idx] = ~req.b[lane][bit_idx];
            end
        end
        return req;
    endfunction

    task automatic send_request(input alu_request_t req);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd   = req.cmd;
        a_x   = req.a[0];
        a_y   = req.a[1];
        a_z   = req.a[2];
        a_w   = req.a[3];
        b_x   = req.b[0];
        b_y   = req.b[1];
        b_z   = req.b[2];
        b_w   = req.b[3];
        scale = req.factor;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(req);
        @(negedge clk);
    endtask

    task automatic send_vectors(input logic [3:0] op, input logic [LANES-1:0][DATA_W-1:0] a,
                                input logic [LANES-1:0][DATA_W-1:0] b,
                                input logic [DATA_W-1:0] factor);
        alu_request_t req;
        req.cmd    = op;
        req.a      = a;
        req.b      = b;
        req.factor = factor;
        send_request(req);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    task automatic wait_all_results();
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ADD;
        a_x = '0;
        a_y = '0;
        a_z = '0;
        a_w = '0;
        b_x = '0;
        b_y = '0;
        b_z = '0;
        b_w = '0;
        scale = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_vectors(CMD_ADD, {4{MAX_WORD}}, {4{MAX_WORD}}, ZERO);
        send_vectors(CMD_ADD, {4{MIN_WORD}}, {4{MIN_WORD}}, ZERO);
        send_vectors(CMD_ADD, {ZERO, ONE_WORD, NEG_LSB, 32'h1234_5678},
                     {NEG_LSB, ONE_WORD, ONE_WORD, 32'hfedc_ba98}, ZERO);
        send_vectors(CMD_SUB, {4{MIN_WORD}}, {4{MAX_WORD}}, ZERO);
        send_vectors(CMD_SUB, {4{MAX_WORD}}, {4{MIN_WORD}}, ZERO);
        send_vectors(CMD_NEGATE, {NEG_LSB, ZERO, MAX_WORD, MIN_WORD}, {4{ZERO}}, ZERO);
        send_vectors(CMD_SCALE, {NEG_LSB, ONE_WORD, MIN_WORD, MAX_WORD}, {4{ZERO}}, MAX_WORD);
        send_vectors(CMD_SCALE, {NEG_LSB, ONE_WORD, MIN_WORD, MAX_WORD}, {4{ZERO}}, MIN_WORD);
        send_vectors(CMD_SCALE, {32'h0000_0003, 32'h0000_0001, NEG_LSB, ONE_WORD},
                     {4{ZERO}}, NEG_HALF);
        send_vectors(CMD_COMPMUL, {MIN_WORD, MAX_WORD, ONE_WORD, NEG_LSB},
                     {MIN_WORD, NEG_LSB, NEG_HALF, 32'h0000_0001}, ZERO);
        send_vectors(CMD_DOT, {4{ONE_WORD}}, {4{ONE_WORD}}, ZERO);
        send_vectors(CMD_DOT, {4{MAX_WORD}}, {4{MAX_WORD}}, ZERO);
        send_vectors(CMD_CROSS, {ZERO, ZERO, ZERO, ONE_WORD}, {ZERO, ZERO, ONE_WORD, ZERO},
                     ZERO);
        send_vectors(CMD_CROSS, {4{MIN_WORD}}, {MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD}, ZERO);
        send_vectors(CMD_QUATMUL, {ZERO, ZERO, ONE_WORD, ZERO}, {ZERO, ONE_WORD, ZERO, ZERO},
                     ZERO);
        send_vectors(CMD_QUATMUL, {4{MIN_WORD}}, {4{MAX_WORD}}, ZERO);
        send_vectors(CMD_MAGSQ, {4{ONE_WORD}}, {4{ZERO}}, ZERO);
        send_vectors(CMD_MAGSQ, {4{MIN_WORD}}, {4{ZERO}}, ZERO);
        send_vectors(CMD_EQUAL, {MIN_WORD, MAX_WORD, NEG_LSB, ZERO},
                     {MIN_WORD, MAX_WORD, NEG_LSB, ZERO}, ZERO);
        send_vectors(CMD_EQUAL, {MIN_WORD, MAX_WORD, NEG_LSB, ZERO},
                     {MAX_WORD, MAX_WORD, NEG_LSB, ZERO}, ZERO);
        send_vectors(CMD_FIRST_UNUSED, {4{MAX_WORD}}, {4{MAX_WORD}}, MAX_WORD);
        send_vectors(CMD_LAST_CODE, {4{NEG_LSB}}, {4{NEG_LSB}}, NEG_LSB);

        send_random(520);
        wait_all_results();

        in_idle_pct = 69;
        out_idle_pct = 12;
        send_random(515);
        wait_all_results();

        in_idle_pct = 0;
        out_idle_pct = 0;
        send_random(515);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
src/qv4alu_pkg.sv
src/quaternion_vector4_alu_core.sv
dv/tb_quaternion_vector4_alu_core.sv
